[hw/rtl/bba_pkg.sv]
// bba_pkg: shared types and constants for the buddy block allocator
// no dependencies
package bba_pkg;

  localparam int ORDER_W  = 5;
  localparam int SIZE_W   = 31;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int OWNER_W  = 16;
  localparam int ORDER_LIMIT = 31;

  // pool order in force after reset
  localparam logic [ORDER_W-1:0] POOL_ORDER_RESET = 5'd5;

  typedef enum logic [0:0] {
    OP_QUERY = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                op;
    logic [OWNER_W-1:0] id;
    logic [ORDER_W-1:0] order;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_QUERY,
    BK_QOUT,
    BK_SCAN_EQ,
    BK_SCAN_GT,
    BK_CHECK,
    BK_SPLIT_DEC,
    BK_SHIFT,
    BK_SPLIT_INS,
    BK_CLAIM,
    BK_RESULT
  } bk_state_t;

endpackage

[hw/rtl/bba_if.sv]
// bba_if: valid/ready channel interfaces for requests and results
// depends on bba_pkg
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bba_pkg::OWNER_W-1:0]  owner_id;
  logic [bba_pkg::SIZE_W-1:0]   request_size;
  modport source (output valid, op, owner_id, request_size, input ready);
  modport sink   (input valid, op, owner_id, request_size, output ready);
endinterface

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::OWNER_W-1:0]   owner;
  logic [bba_pkg::COUNT_W-1:0]   block_count;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic                          last;
  modport source (output valid, owner, block_count, status, last, input ready);
  modport sink   (input valid, owner, block_count, status, last, output ready);
endinterface

[hw/rtl/buddy_block_allocator_unit.sv]
// buddy_block_allocator_unit: top level of the buddy block allocator
// depends on bba_pkg, bba_if, bba_front and bba_back
//
// One item at a time: a query reads and reports each block in the list in
// turn; an allocate makes up to two scans through the block memory (one
// write port, one registered read port), plus for each split a decrement,
// a move per entry after the picked block, since the list tail shifts one
// place up the memory, and an insert, then a claim and the result. The
// front queue holds two commands so requests can arrive while the list is
// being worked on. No clearing pass after reset.
module buddy_block_allocator_unit #(
  parameter int MAX_BLOCKS = 32,
  parameter int OWNER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bba_pkg::ORDER_W-1:0] cfg_wdata,
  bba_req_if.sink                     req,
  bba_rsp_if.source                   rsp
);

  logic          cmd_valid;
  logic          cmd_ready;
  bba_pkg::cmd_t cmd;
  logic          busy;

  bba_front #(.OWNER_BITS(OWNER_BITS)) u_front (
    .clk, .rst, .req, .cmd_valid, .cmd_ready, .cmd
  );

  bba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk, .rst, .cfg_we, .cfg_order(cfg_wdata), .cmd_valid, .cmd_ready, .cmd,
    .rsp, .busy
  );

  // a result is only shown while the back end is working on something
  a_rsp_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> busy) else $error("result without work");

  // no command is taken while a configuration write happens
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !cmd_ready) else $error("command taken during config");

  // a pending result holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");

endmodule

[hw/rtl/bba_front.sv]
// bba_front: accepts requests, rounds the size to an order, queues commands
// depends on bba_pkg and bba_if
module bba_front #(
  parameter int OWNER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  bba_req_if.sink        req,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output bba_pkg::cmd_t  cmd
);

  localparam int QD = 2;

  bba_pkg::cmd_t q [QD];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  logic [bba_pkg::ORDER_W-1:0] order_c;
  logic [bba_pkg::OWNER_W-1:0] id_c;
  logic [bba_pkg::OWNER_W-1:0] omask;
  logic                        push;
  logic                        pop;

  // smallest order whose power covers the size, saturating at the limit
  always_comb begin
    order_c = 5'(bba_pkg::ORDER_LIMIT);
    for (int k = bba_pkg::ORDER_LIMIT - 1; k >= 0; k--) begin
      if ((32'(1) << k) >= {1'b0, req.request_size}) order_c = 5'(k);
    end
  end

  // owner id kept in its low OWNER_BITS bits
  assign omask = (OWNER_BITS >= bba_pkg::OWNER_W) ? '1 :
                 bba_pkg::OWNER_W'((32'(1) << OWNER_BITS) - 1);
  assign id_c  = req.owner_id & omask;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= '{op: bba_pkg::op_t'(req.op), id: id_c, order: order_c};
  end

endmodule

[hw/rtl/bba_back.sv]
// bba_back: block list memory and the sequencer that queries and splits it
// depends on bba_pkg and bba_if
module bba_back #(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bba_pkg::ORDER_W-1:0] cfg_order,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  bba_pkg::cmd_t               cmd,
  bba_rsp_if.source                   rsp,
  output logic                        busy
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = bba_pkg::ORDER_W + 1 + bba_pkg::OWNER_W;

  // entry memory {order, used, owner}; epoch-free: entries past the total
  // are never used before being written
  logic [EW-1:0] mem [MAX_BLOCKS];

  bba_pkg::bk_state_t state, state_next;
  bba_pkg::cmd_t      cur;
  logic [CW-1:0]      total;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pick;
  logic [CW-1:0]      n;
  logic [bba_pkg::ORDER_W-1:0] pick_ord;
  logic [bba_pkg::ORDER_W-1:0] splits;
  logic [EW-1:0]      rd_data;
  logic               rd_pend;
  logic [bba_pkg::STATUS_W-1:0] st;

  logic [bba_pkg::ORDER_W-1:0] e_ord;
  logic                        e_used;
  logic [bba_pkg::OWNER_W-1:0] e_own;

  logic          out_valid;
  logic [bba_pkg::OWNER_W-1:0] out_owner;
  logic [bba_pkg::COUNT_W-1:0] out_count;
  logic [bba_pkg::STATUS_W-1:0] out_status;
  logic          out_last;

  logic          we;
  logic [IW-1:0] wa;
  logic [EW-1:0] wd;
  logic [IW-1:0] ra;

  assign {e_ord, e_used, e_own} = rd_data;

  assign rsp.valid       = out_valid;
  assign rsp.owner       = out_owner;
  assign rsp.block_count = out_count;
  assign rsp.status      = out_status;
  assign rsp.last        = out_last;
  assign busy            = (state != bba_pkg::BK_IDLE) || out_valid;
  assign cmd_ready       = (state == bba_pkg::BK_IDLE) && !cfg_we;

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[ra];
  end

  // next state, memory control
  always_comb begin
    state_next = state;
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = idx[IW-1:0];
    unique case (state)
      bba_pkg::BK_IDLE: begin
        if (cmd_valid && cmd_ready)
          state_next = (cmd.op == bba_pkg::OP_QUERY) ? bba_pkg::BK_QUERY
                                                     : bba_pkg::BK_SCAN_EQ;
        ra = '0;
      end
      bba_pkg::BK_QUERY: if (rd_pend) state_next = bba_pkg::BK_QOUT;
      bba_pkg::BK_QOUT: begin
        if (!out_valid || rsp.ready)
          state_next = (idx + 1'b1 == total) ? bba_pkg::BK_IDLE : bba_pkg::BK_QUERY;
      end
      bba_pkg::BK_SCAN_EQ: begin
        // fetch the entry that the next cycle looks at
        ra = (idx + 1'b1 == total) ? '0 : IW'(idx + 1'b1);
        if (rd_pend) begin
          if (!e_used && e_ord == cur.order) begin
            state_next = bba_pkg::BK_CLAIM;
          end else if (idx + 1'b1 == total) begin
            state_next = bba_pkg::BK_SCAN_GT;
          end
        end
      end
      bba_pkg::BK_SCAN_GT: begin
        ra = IW'(idx + 1'b1);
        if (rd_pend) begin
          if (!e_used && e_ord > cur.order) state_next = bba_pkg::BK_CHECK;
          else if (idx + 1'b1 == total) state_next = bba_pkg::BK_RESULT;
        end
      end
      bba_pkg::BK_CHECK: begin
        if ({1'b0, total} + (CW+1)'(splits) > (CW+1)'(MAX_BLOCKS))
          state_next = bba_pkg::BK_RESULT;
        else
          state_next = bba_pkg::BK_SPLIT_DEC;
      end
      bba_pkg::BK_SPLIT_DEC: begin
        if (splits == '0) begin
          state_next = bba_pkg::BK_CLAIM;
        end else begin
          we = 1'b1;
          wa = pick[IW-1:0];
          wd = {pick_ord - 1'b1, 1'b0, {bba_pkg::OWNER_W{1'b0}}};
          ra = total[IW-1:0] - 1'b1;
          state_next = (total > pick + 1'b1) ? bba_pkg::BK_SHIFT : bba_pkg::BK_SPLIT_INS;
        end
      end
      bba_pkg::BK_SHIFT: begin
        ra = n[IW-1:0] - 1'b1;
        if (rd_pend) begin
          we = 1'b1;
          wa = n[IW-1:0];
          wd = rd_data;
          ra = n[IW-1:0] - IW'(2);
          if (n - 1'b1 == pick + 1'b1) state_next = bba_pkg::BK_SPLIT_INS;
        end
      end
      bba_pkg::BK_SPLIT_INS: begin
        we = 1'b1;
        wa = IW'(pick + 1'b1);
        wd = {pick_ord, 1'b0, {bba_pkg::OWNER_W{1'b0}}};
        state_next = bba_pkg::BK_SPLIT_DEC;
      end
      bba_pkg::BK_CLAIM: begin
        we = 1'b1;
        wa = pick[IW-1:0];
        wd = {cur.order, 1'b1, cur.id};
        state_next = bba_pkg::BK_RESULT;
      end
      bba_pkg::BK_RESULT: if (!out_valid || rsp.ready) state_next = bba_pkg::BK_IDLE;
      default: state_next = bba_pkg::BK_IDLE;
    endcase
    // reset and pool writes leave one free block at entry 0
    if (rst || cfg_we) begin
      we = 1'b1;
      wa = '0;
      wd = {rst ? bba_pkg::POOL_ORDER_RESET : cfg_order, 1'b0, {bba_pkg::OWNER_W{1'b0}}};
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::BK_IDLE;
      total     <= CW'(1);
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      rd_pend <= 1'b0;
      unique case (state)
        bba_pkg::BK_IDLE: begin
          cur <= cmd;
          idx <= '0;
          st  <= bba_pkg::ST_NO_FIT;
          if (cmd_valid && cmd_ready) rd_pend <= 1'b1;
        end
        bba_pkg::BK_QUERY: ;
        bba_pkg::BK_QOUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_owner  <= e_used ? e_own : '0;
            out_count  <= bba_pkg::COUNT_W'(total);
            out_status <= bba_pkg::ST_OK;
            out_last   <= (idx + 1'b1 == total);
            idx        <= idx + 1'b1;
            rd_pend    <= 1'b1;
          end
        end
        bba_pkg::BK_SCAN_EQ: begin
          if (rd_pend) begin
            pick <= idx;
            if (!(!e_used && e_ord == cur.order)) begin
              idx     <= (idx + 1'b1 == total) ? '0 : idx + 1'b1;
              rd_pend <= 1'b1;
            end
          end
        end
        bba_pkg::BK_SCAN_GT: begin
          if (rd_pend) begin
            pick     <= idx;
            pick_ord <= e_ord;
            splits   <= e_ord - cur.order;
            if (!(!e_used && e_ord > cur.order) && idx + 1'b1 != total) begin
              idx     <= idx + 1'b1;
              rd_pend <= 1'b1;
            end
          end
        end
        bba_pkg::BK_CHECK: begin
          st <= bba_pkg::ST_FULL;
          n  <= total;
        end
        bba_pkg::BK_SPLIT_DEC: begin
          if (splits != '0) begin
            pick_ord <= pick_ord - 1'b1;
            n        <= total;
            rd_pend  <= 1'b1;
          end
        end
        bba_pkg::BK_SHIFT: begin
          if (rd_pend) begin
            n       <= n - 1'b1;
            rd_pend <= 1'b1;
          end
        end
        bba_pkg::BK_SPLIT_INS: begin
          total  <= total + 1'b1;
          splits <= splits - 1'b1;
        end
        bba_pkg::BK_CLAIM: st <= bba_pkg::ST_OK;
        bba_pkg::BK_RESULT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_owner  <= (st == bba_pkg::ST_OK) ? cur.id : '0;
            out_count  <= bba_pkg::COUNT_W'(total);
            out_status <= st;
            out_last   <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cfg_we) total <= CW'(1);
    end
  end

endmodule

[tb/sv/tb.sv]
// tb: self-checking testbench for buddy_block_allocator_unit
// depends on bba_pkg, bba_if and the allocator rtl; drives requests, checks results
// against an in-bench model of the block list
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 450;
  localparam int PHASE_LEN = 30;

  typedef enum int {ROW_QUERY, ROW_ALLOC, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [15:0]      id;
    logic [30:0]      size;
    bit               typed;
    logic [15:0]      t_owner;
    logic [5:0]       t_count;
    bba_pkg::status_t t_status;
  } stim_row_t;

  typedef struct {
    logic [15:0]      owner;
    logic [5:0]       count;
    bba_pkg::status_t status;
    logic             last;
  } grant_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [bba_pkg::ORDER_W-1:0] cfg_wdata;

  bba_req_if req_ch();
  bba_rsp_if rsp_ch();

  buddy_block_allocator_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_ch), .rsp(rsp_ch)
  );

  // block list model
  logic [4:0]  list_order[NBLK];
  bit          list_used[NBLK];
  logic [15:0] list_owner[NBLK];
  int          list_count;
  logic [4:0]  pool_ord;

  grant_t pending_rsp[$];
  int     errors = 0;
  int     n_items = 0, n_results = 0, n_alloc_ok = 0, n_no_fit = 0, n_full = 0;
  int     n_query = 0, n_cfg = 0;
  int     idle_cycles = 0;
  bit     calm_stall = 0;

  function automatic void list_clear(logic [4:0] po);
    for (int i = 0; i < NBLK; i++) begin
      list_order[i] = '0;
      list_used[i] = 0;
      list_owner[i] = '0;
    end
    pool_ord = po;
    list_order[0] = po;
    list_count = 1;
  endfunction

  function automatic int size_to_order(logic [30:0] sz);
    int k;
    k = 0;
    while (k < bba_pkg::ORDER_LIMIT && (64'd1 << k) < {33'd0, sz}) k++;
    return k;
  endfunction

  function automatic void push_grant(logic [15:0] own, bba_pkg::status_t st, logic lst);
    grant_t g;
    g.owner = own;
    g.count = list_count[5:0];
    g.status = st;
    g.last = lst;
    pending_rsp.push_back(g);
  endfunction

  // apply one accepted transaction to the list and queue its results
  function automatic void predict_item(bba_pkg::op_t op, logic [15:0] id,
                                       logic [30:0] sz);
    int p, pick, splits;
    if (op == bba_pkg::OP_QUERY) begin
      n_query++;
      for (int i = 0; i < list_count; i++)
        push_grant(list_used[i] ? list_owner[i] : 16'd0, bba_pkg::ST_OK,
                   i + 1 == list_count);
      return;
    end
    p = size_to_order(sz);
    for (int i = 0; i < list_count; i++) begin
      if (!list_used[i] && list_order[i] == p) begin
        list_used[i] = 1;
        list_owner[i] = id;
        push_grant(id, bba_pkg::ST_OK, 1);
        n_alloc_ok++;
        return;
      end
    end
    pick = -1;
    for (int i = 0; i < list_count; i++) begin
      if (pick < 0 && !list_used[i] && list_order[i] > p) pick = i;
    end
    if (pick < 0) begin
      push_grant(16'd0, bba_pkg::ST_NO_FIT, 1);
      n_no_fit++;
      return;
    end
    splits = list_order[pick] - p;
    if (list_count + splits > NBLK) begin
      push_grant(16'd0, bba_pkg::ST_FULL, 1);
      n_full++;
      return;
    end
    // halve the picked block, upper half goes right after it
    for (int j = 0; j < splits; j++) begin
      list_order[pick] = list_order[pick] - 1;
      for (int n = list_count; n > pick + 1; n--) begin
        list_order[n] = list_order[n-1];
        list_used[n] = list_used[n-1];
        list_owner[n] = list_owner[n-1];
      end
      list_order[pick+1] = list_order[pick];
      list_used[pick+1] = 0;
      list_owner[pick+1] = '0;
      list_count++;
    end
    list_used[pick] = 1;
    list_owner[pick] = id;
    push_grant(id, bba_pkg::ST_OK, 1);
    n_alloc_ok++;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // known values from time zero
  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    req_ch.valid = 0;
    req_ch.op = 0;
    req_ch.owner_id = '0;
    req_ch.request_size = '0;
    rsp_ch.ready = 0;
  end

  // result sink with random stalls
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm_stall ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_ch.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      @(negedge clk);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result owner=%0h count=%0d status=%0d last=%0b",
                 $realtime, rsp_ch.owner, rsp_ch.block_count, rsp_ch.status, rsp_ch.last);
      end else begin
        grant_t g;
        g = pending_rsp.pop_front();
        if (rsp_ch.owner !== g.owner) begin
          errors++;
          $display("%0t: owner exp %0h got %0h", $realtime, g.owner, rsp_ch.owner);
        end
        if (rsp_ch.block_count !== g.count) begin
          errors++;
          $display("%0t: block_count exp %0d got %0d", $realtime, g.count,
                   rsp_ch.block_count);
        end
        if (rsp_ch.status !== g.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $realtime, g.status, rsp_ch.status);
        end
        if (rsp_ch.last !== g.last) begin
          errors++;
          $display("%0t: last exp %0b got %0b", $realtime, g.last, rsp_ch.last);
        end
      end
    end
  end

  // watchdog on transaction progress
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $realtime,
               pending_rsp.size());
      $display("FAIL buddy_block_allocator_unit");
      $finish;
    end
  end

  // stop sending, then wait until every expected result is out
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_pool(logic [4:0] po);
    wait_drained();
    @(negedge clk);
    req_ch.valid <= 0;
    cfg_we <= 1;
    cfg_wdata <= po;
    @(negedge clk);
    cfg_we <= 0;
    list_clear(po);
    n_cfg++;
  endtask

  // send one request transaction; typed rows replace the model's expectation
  task automatic send_item(bba_pkg::op_t op, logic [15:0] id, logic [30:0] sz, bit fast,
                           bit typed = 0, logic [15:0] t_owner = '0,
                           logic [5:0] t_count = '0,
                           bba_pkg::status_t t_status = bba_pkg::ST_OK);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.op <= op;
    req_ch.owner_id <= id;
    req_ch.request_size <= sz;
    do @(posedge clk); while (!req_ch.ready);
    n_items++;
    if (typed) begin
      predict_item(op, id, sz);
      void'(pending_rsp.pop_back());
      pending_rsp.push_back('{t_owner, t_count, t_status, 1'b1});
    end else begin
      predict_item(op, id, sz);
    end
  endtask

  stim_row_t dir_rows[] = '{
    '{ROW_QUERY, 16'h0,    31'd0,          1, 16'h0,    6'd1,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'hFFFF, 31'd0,          1, 16'hFFFF, 6'd6,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h0001, 31'd1,          1, 16'h0001, 6'd6,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h0000, 31'd3,          1, 16'h0000, 6'd6,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h0002, 31'h40000000,   1, 16'h0,    6'd6,  bba_pkg::ST_NO_FIT},
    '{ROW_ALLOC, 16'h0003, 31'h7FFFFFFF,   1, 16'h0,    6'd6,  bba_pkg::ST_NO_FIT},
    '{ROW_ALLOC, 16'h5A5A, 31'd5,          0, 16'h0,    6'd0,  bba_pkg::ST_OK},
    '{ROW_QUERY, 16'hFFFF, 31'h7FFFFFFF,   0, 16'h0,    6'd0,  bba_pkg::ST_OK},
    '{ROW_CFG,   16'h0,    31'd30,         0, 16'h0,    6'd0,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h1234, 31'd1,          1, 16'h1234, 6'd31, bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h8000, 31'd1,          1, 16'h8000, 6'd31, bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h4321, 31'd1,          1, 16'h4321, 6'd32, bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h0ABC, 31'd1,          1, 16'h0ABC, 6'd32, bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h0DEF, 31'd1,          1, 16'h0,    6'd32, bba_pkg::ST_FULL},
    '{ROW_QUERY, 16'h0,    31'd0,          0, 16'h0,    6'd0,  bba_pkg::ST_OK},
    '{ROW_CFG,   16'h0,    31'd0,          0, 16'h0,    6'd0,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h7777, 31'd2,          1, 16'h0,    6'd1,  bba_pkg::ST_NO_FIT},
    '{ROW_ALLOC, 16'h7777, 31'd1,          1, 16'h7777, 6'd1,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h1111, 31'd0,          1, 16'h0,    6'd1,  bba_pkg::ST_NO_FIT},
    '{ROW_QUERY, 16'h0,    31'd0,          1, 16'h7777, 6'd1,  bba_pkg::ST_OK},
    '{ROW_CFG,   16'h0,    31'd31,         0, 16'h0,    6'd0,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h2222, 31'h7FFFFFFF,   1, 16'h2222, 6'd1,  bba_pkg::ST_OK},
    '{ROW_ALLOC, 16'h3333, 31'd1,          1, 16'h0,    6'd1,  bba_pkg::ST_NO_FIT}
  };

  // stimulus
  initial begin
    int sent, phase_pos, o, r, ph;
    logic [30:0] sz;
    logic [4:0] po;
    bba_pkg::op_t op;
    list_clear(5'd5);
    ph = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed table
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG)
        write_pool(dir_rows[k].size[4:0]);
      else
        send_item(dir_rows[k].kind == ROW_QUERY ? bba_pkg::OP_QUERY : bba_pkg::OP_ALLOC,
                  dir_rows[k].id, dir_rows[k].size, k < 4, dir_rows[k].typed,
                  dir_rows[k].t_owner, dir_rows[k].t_count, dir_rows[k].t_status);
    end

    // random phases, each under a fresh pool order
    sent = 0;
    phase_pos = PHASE_LEN;
    while (sent < RAND_ITEMS) begin
      if (phase_pos >= PHASE_LEN) begin
        ph = sent / PHASE_LEN;
        po = (ph == 0) ? 5'd31 : (ph == 1) ? 5'd0 : (ph == 2) ? 5'd30 :
             5'($urandom_range(0, 31));
        write_pool(po);
        calm_stall = (ph % 4 == 3);
        phase_pos = 0;
      end
      // hold off mid-phase until the list work is all out
      if (phase_pos == PHASE_LEN / 2 && ph % 3 == 1) wait_drained();
      r = $urandom_range(0, 99);
      op = (r < 15) ? bba_pkg::OP_QUERY : bba_pkg::OP_ALLOC;
      if (r >= 90) begin
        sz = 31'($urandom());
      end else begin
        o = $urandom_range(0, pool_ord);
        if (o > 30) o = 30;
        if (o == 0) sz = 31'($urandom_range(0, 1));
        else sz = 31'($urandom_range((32'd1 << (o - 1)) + 1, 32'd1 << o));
      end
      send_item(op, 16'($urandom()), sz, calm_stall);
      sent++;
      phase_pos++;
    end

    @(negedge clk);
    req_ch.valid <= 0;
    r = 0;
    while (pending_rsp.size() > 0 && r < 200000) begin
      @(posedge clk);
      r++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d pool writes", n_items, n_results,
             n_cfg);
    $display("allocs ok %0d, no fit %0d, table full %0d, queries %0d", n_alloc_ok,
             n_no_fit, n_full, n_query);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("PASS buddy_block_allocator_unit");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_rsp.size());
      $display("FAIL buddy_block_allocator_unit");
    end
    $finish;
  end
endmodule
